@@ sv/srt_pkg.sv @@
package srt_pkg;

	// sizing
	localparam int MAX_PROCS = 16;
	localparam int TIME_BITS = 16;

	localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CNT_W = $clog2(MAX_PROCS + 1);
	// arrival plus the sum of all bursts stays below (MAX_PROCS + 1) << TIME_BITS
	localparam int SIM_W = TIME_BITS + CNT_W;

	// port widths
	localparam int ARRIVAL_W = 16;
	localparam int BURST_W   = 16;
	localparam int PIDX_W    = 4;
	localparam int FINISH_W  = 21;
	localparam int WAIT_W    = 20;
	localparam int TOTAL_W   = 24;

	// memory words
	localparam int REC_W = 2 * TIME_BITS;       // arrival, burst
	localparam int DYN_W = TIME_BITS + SIM_W;   // remain, finish

	// one entry coming back from the memories during a scan
	typedef struct packed {
		logic                 vld;
		logic [IDX_W-1:0]     idx;
		logic [TIME_BITS-1:0] arrival;
		logic [TIME_BITS-1:0] remain;
	} scan_t;

	// running result of a scan
	typedef struct packed {
		logic                 have_sel;
		logic [IDX_W-1:0]     sel;
		logic [TIME_BITS-1:0] sel_rem;
		logic                 have_next;
		logic [TIME_BITS-1:0] next_arr;
	} pick_t;

	// control for the report stage
	typedef struct packed {
		logic             vld;
		logic             last;
		logic [IDX_W-1:0] idx;
	} rpt_t;

endpackage

@@ sv/srt_ram.sv @@
module srt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/srt_pick.sv @@
module srt_pick (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clr,
	input  srt_pkg::scan_t                 scan,
	input  logic [srt_pkg::SIM_W-1:0]      sim_time,
	output srt_pkg::pick_t                 pick
);

	srt_pkg::pick_t pick_q;
	logic live;
	logic arrived;
	logic take_sel;
	logic take_next;

	always_comb begin
		live      = scan.vld && (scan.remain != '0);
		arrived   = srt_pkg::SIM_W'(scan.arrival) <= sim_time;
		// strict less keeps the earlier entry on a tie
		take_sel  = live && arrived &&
			(!pick_q.have_sel || (scan.remain < pick_q.sel_rem));
		take_next = live && !arrived &&
			(!pick_q.have_next || (scan.arrival < pick_q.next_arr));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pick_q <= '0;
		end else if (clr) begin
			pick_q.have_sel  <= 1'b0;
			pick_q.have_next <= 1'b0;
		end else begin
			if (take_sel) begin
				pick_q.have_sel <= 1'b1;
				pick_q.sel      <= scan.idx;
				pick_q.sel_rem  <= scan.remain;
			end
			if (take_next) begin
				pick_q.have_next <= 1'b1;
				pick_q.next_arr  <= scan.arrival;
			end
		end
	end

	assign pick = pick_q;

endmodule

@@ sv/srt_report.sv @@
module srt_report (
	input  logic                              clk,
	input  logic                              arst_n,
	input  srt_pkg::rpt_t                     rpt,
	input  logic [srt_pkg::SIM_W-1:0]         finish,
	input  logic [srt_pkg::TIME_BITS-1:0]     arr,
	input  logic [srt_pkg::TIME_BITS-1:0]     bst,
	output logic                              strobe,
	output logic [srt_pkg::PIDX_W-1:0]        proc_index,
	output logic [srt_pkg::FINISH_W-1:0]      finish_time,
	output logic [srt_pkg::WAIT_W-1:0]        wait_time,
	output logic [srt_pkg::TOTAL_W-1:0]       total_wait,
	output logic                              last_result
);

	logic [srt_pkg::SIM_W-1:0]   wait_full;
	logic [srt_pkg::TOTAL_W-1:0] total_nxt;
	logic [srt_pkg::TOTAL_W-1:0] total_q;
	logic                        strobe_q;
	logic [srt_pkg::PIDX_W-1:0]  idx_q;
	logic [srt_pkg::FINISH_W-1:0] finish_q;
	logic [srt_pkg::WAIT_W-1:0]  wait_q;
	logic [srt_pkg::TOTAL_W-1:0] total_out_q;
	logic                        last_q;

	always_comb begin
		wait_full = finish - srt_pkg::SIM_W'(arr) - srt_pkg::SIM_W'(bst);
		total_nxt = total_q + srt_pkg::TOTAL_W'(wait_full);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			total_q  <= '0;
		end else begin
			strobe_q <= rpt.vld;
			if (rpt.vld) begin
				total_q <= rpt.last ? '0 : total_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rpt.vld) begin
			idx_q       <= srt_pkg::PIDX_W'(rpt.idx);
			finish_q    <= srt_pkg::FINISH_W'(finish);
			wait_q      <= srt_pkg::WAIT_W'(wait_full);
			total_out_q <= rpt.last ? total_nxt : '0;
			last_q      <= rpt.last;
		end
	end

	assign strobe      = strobe_q;
	assign proc_index  = idx_q;
	assign finish_time = finish_q;
	assign wait_time   = wait_q;
	assign total_wait  = total_out_q;
	assign last_result = strobe_q & last_q;

endmodule

@@ sv/shortest_remaining_time_scheduler.sv @@
// Preemptive shortest-remaining-time-first scheduler. Process requests
// (arrival, burst) load one per cycle while busy is low; up to 16 are kept
// and further ones are dropped. The request with final_record set starts
// a run: busy rises, the schedule is worked out event by event (a
// completion or an arrival), and one result per loaded process then
// leaves in load order, each on a single strobe cycle, with the summed
// waiting time on the result flagged last_result. The receiver cannot
// stall, so every strobe must be taken when it appears. A run over n
// processes has at most 2n events; every event step scans all n entries
// of the process memory through its single read port, and a last sweep
// reports the results; busy falls on the cycle the last result is
// strobed, and the next batch may load right away.
module shortest_remaining_time_scheduler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [srt_pkg::ARRIVAL_W-1:0]     arrival,
	input  logic [srt_pkg::BURST_W-1:0]       burst,
	input  logic                              final_record,
	output logic                              strobe,
	output logic [srt_pkg::PIDX_W-1:0]        proc_index,
	output logic [srt_pkg::FINISH_W-1:0]      finish_time,
	output logic [srt_pkg::WAIT_W-1:0]        wait_time,
	output logic [srt_pkg::TOTAL_W-1:0]       total_wait,
	output logic                              last_result
);

	// sequencer states
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,  // loading requests
		S_CHECK  = 5'b00010,  // all done? pick scan or report
		S_SCAN   = 5'b00100,  // sweep the memories, find runner and next arrival
		S_UPDATE = 5'b01000,  // advance time, write back the runner
		S_REPORT = 5'b10000   // sweep again and emit results
	} state_t;

	state_t state_q;

	logic [srt_pkg::CNT_W-1:0] loaded_q;   // processes in this batch
	logic [srt_pkg::CNT_W-1:0] done_q;     // processes finished
	logic [srt_pkg::SIM_W-1:0] time_q;     // simulated time
	logic [srt_pkg::CNT_W-1:0] issue_q;    // next address to read in a sweep

	logic                      rd_vld_s1;  // read data valid
	logic [srt_pkg::IDX_W-1:0] rd_idx_s1;  // address of that data

	// input side
	logic                          accept;
	logic                          ld_we;
	logic [srt_pkg::TIME_BITS-1:0] arr_in;
	logic [srt_pkg::TIME_BITS-1:0] bst_in;

	// memory ports
	logic                          rd_en;
	logic [srt_pkg::IDX_W-1:0]     rd_addr;
	logic                          dyn_we;
	logic [srt_pkg::IDX_W-1:0]     dyn_waddr;
	logic [srt_pkg::DYN_W-1:0]     dyn_wdata;
	logic [srt_pkg::REC_W-1:0]     rec_rdata;
	logic [srt_pkg::DYN_W-1:0]     dyn_rdata;

	logic [srt_pkg::TIME_BITS-1:0] rd_arr;
	logic [srt_pkg::TIME_BITS-1:0] rd_bst;
	logic [srt_pkg::TIME_BITS-1:0] rd_rem;
	logic [srt_pkg::SIM_W-1:0]     rd_fin;
	logic                          last_rd;

	// scan unit
	srt_pkg::scan_t scan;
	srt_pkg::pick_t pick;
	srt_pkg::rpt_t  rpt;

	// update step
	logic [srt_pkg::SIM_W-1:0]     gap;
	logic [srt_pkg::SIM_W-1:0]     rem_ext;
	logic [srt_pkg::SIM_W-1:0]     run_len;
	logic [srt_pkg::TIME_BITS-1:0] new_rem;
	logic [srt_pkg::SIM_W-1:0]     new_time;

	// ---------------------------------------------------------------- input
	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign arr_in = srt_pkg::TIME_BITS'(arrival);
	assign bst_in = srt_pkg::TIME_BITS'(burst);
	// requests past capacity are dropped but a final one still starts the run
	assign ld_we  = accept && (loaded_q < srt_pkg::CNT_W'(srt_pkg::MAX_PROCS));

	// ---------------------------------------------------------------- reads
	assign rd_en   = ((state_q == S_SCAN) || (state_q == S_REPORT)) && (issue_q < loaded_q);
	assign rd_addr = issue_q[srt_pkg::IDX_W-1:0];

	assign {rd_arr, rd_bst} = rec_rdata;
	assign {rd_rem, rd_fin} = dyn_rdata;

	assign last_rd = rd_vld_s1 &&
		((srt_pkg::CNT_W'(rd_idx_s1) + srt_pkg::CNT_W'(1)) == loaded_q);

	// ---------------------------------------------------------------- update math
	always_comb begin
		// the next arrival lies strictly ahead of the current time
		gap      = srt_pkg::SIM_W'(pick.next_arr) - time_q;
		rem_ext  = srt_pkg::SIM_W'(pick.sel_rem);
		run_len  = (pick.have_next && (gap < rem_ext)) ? gap : rem_ext;
		new_rem  = pick.sel_rem - srt_pkg::TIME_BITS'(run_len);
		new_time = time_q + run_len;
	end

	// ---------------------------------------------------------------- writes
	// load writes in idle, runner write-back in update; the sequencer keeps
	// the write-back in a cycle of its own, clear of any sweep read
	always_comb begin
		dyn_we    = 1'b0;
		dyn_waddr = loaded_q[srt_pkg::IDX_W-1:0];
		dyn_wdata = {bst_in, srt_pkg::SIM_W'(arr_in)};
		if (state_q == S_UPDATE) begin
			dyn_we    = pick.have_sel;
			dyn_waddr = pick.sel;
			dyn_wdata = {new_rem, new_time};
		end else begin
			dyn_we = ld_we;
		end
	end

	srt_ram #(
		.WIDTH (srt_pkg::REC_W),
		.DEPTH (srt_pkg::MAX_PROCS)
	) u_rec_ram (
		.clk   (clk),
		.we    (ld_we),
		.waddr (loaded_q[srt_pkg::IDX_W-1:0]),
		.wdata ({arr_in, bst_in}),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rec_rdata)
	);

	srt_ram #(
		.WIDTH (srt_pkg::DYN_W),
		.DEPTH (srt_pkg::MAX_PROCS)
	) u_dyn_ram (
		.clk   (clk),
		.we    (dyn_we),
		.waddr (dyn_waddr),
		.wdata (dyn_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (dyn_rdata)
	);

	// ---------------------------------------------------------------- scan unit
	always_comb begin
		scan.vld     = rd_vld_s1 && (state_q == S_SCAN);
		scan.idx     = rd_idx_s1;
		scan.arrival = rd_arr;
		scan.remain  = rd_rem;
	end

	srt_pick u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (state_q == S_CHECK),
		.scan     (scan),
		.sim_time (time_q),
		.pick     (pick)
	);

	// ---------------------------------------------------------------- report
	always_comb begin
		rpt.vld  = rd_vld_s1 && (state_q == S_REPORT);
		rpt.last = last_rd;
		rpt.idx  = rd_idx_s1;
	end

	srt_report u_report (
		.clk         (clk),
		.arst_n      (arst_n),
		.rpt         (rpt),
		.finish      (rd_fin),
		.arr         (rd_arr),
		.bst         (rd_bst),
		.strobe      (strobe),
		.proc_index  (proc_index),
		.finish_time (finish_time),
		.wait_time   (wait_time),
		.total_wait  (total_wait),
		.last_result (last_result)
	);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			loaded_q  <= '0;
			done_q    <= '0;
			time_q    <= '0;
			issue_q   <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			rd_idx_s1 <= rd_addr;
			if (rd_en) begin
				issue_q <= issue_q + srt_pkg::CNT_W'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (ld_we) begin
						loaded_q <= loaded_q + srt_pkg::CNT_W'(1);
						// a zero burst is finished at its arrival
						if (bst_in == '0) begin
							done_q <= done_q + srt_pkg::CNT_W'(1);
						end
					end
					if (accept && final_record) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					issue_q <= '0;
					state_q <= (done_q == loaded_q) ? S_REPORT : S_SCAN;
				end
				S_SCAN: begin
					if (last_rd) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					if (pick.have_sel) begin
						time_q <= new_time;
						if (new_rem == '0) begin
							done_q <= done_q + srt_pkg::CNT_W'(1);
						end
					end else begin
						// idle stretch: jump to the next arrival
						time_q <= srt_pkg::SIM_W'(pick.next_arr);
					end
					state_q <= S_CHECK;
				end
				S_REPORT: begin
					if (last_rd) begin
						loaded_q <= '0;
						done_q   <= '0;
						time_q   <= '0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- checks
	// an update always has something to do while processes remain
	a_update_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPDATE) |-> (pick.have_sel || pick.have_next))
		else $error("update step with no runner and no pending arrival");

	// the finished count never runs past the batch
	a_done_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		done_q <= loaded_q)
		else $error("done count exceeds loaded count");

	// results only come out of a report sweep
	a_strobe_from_report: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == S_REPORT))
		else $error("result strobe outside report sweep");

	// write-back never shares a cycle with a sweep read
	a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPDATE) |-> !rd_en && !rd_vld_s1)
		else $error("write-back overlaps a memory read");

	// the last result closes the run
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		last_result |-> (loaded_q == '0) || $past(state_q == S_REPORT, 1) && !busy
			|| (state_q == S_IDLE))
		else $error("last result while a run is still open");

endmodule
